// ===== src/positional_list_engine_assert.svh =====
// Assertion macros for the positional list engine.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ple_pkg.sv =====
// Shared constants for the positional list engine.
// No dependencies.
package ple_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int POS_W        = 6;
  localparam int VAL_W        = 32;
  localparam int MODE_W       = 2;
  localparam int STAT_W       = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd3;

endpackage

// ===== src/ple_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are not reset.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/positional_list_engine.sv =====
// Positional list engine: ordered list of signed words in one RAM plus a count.
// Insert at p with n entries: shifts entries p..n up (one RAM read and write each), then writes the value.
// Delete at p: shifts entries p+1..n down. Search reads every entry; an empty list reads none.
// Error statuses skip the RAM. Next item is taken the cycle after the last result loads.
// Reset clears the entry count and control; RAM contents are left as they are.
// Depends on ple_pkg, ple_ram and positional_list_engine_assert.svh.
`include "positional_list_engine_assert.svh"

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero[39:38]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // match_position[5:0], entry_count[11:6], zero[15:12]
  output logic [2:0]  m_tuser,   // status[1:0], match_found[2]
  output logic        m_tlast
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int XW    = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS       = 3'd1;
  localparam logic [2:0] S_INS_DRAIN = 3'd2;
  localparam logic [2:0] S_INS_PUT   = 3'd3;
  localparam logic [2:0] S_DEL       = 3'd4;
  localparam logic [2:0] S_DEL_DRAIN = 3'd5;
  localparam logic [2:0] S_RESP      = 3'd6;
  localparam logic [2:0] S_SRCH      = 3'd7;

  logic [2:0]        state;
  logic              in_srch_end;
  logic [CNT_W-1:0]  length;
  logic [AW-1:0]     cur;
  logic              issuing;
  logic              pend;
  logic [AW-1:0]     pend_wa;
  logic [POS_W-1:0]  pos_reg;
  logic [VAL_W-1:0]  val_reg;
  logic [STAT_W-1:0] st_reg;
  logic              cmp_v;
  logic [AW-1:0]     cmp_idx;
  logic              held_v;
  logic [POS_W-1:0]  held_pos;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [VAL_W-1:0]  wdata;
  logic              re;
  logic [VAL_W-1:0]  rdata;

  logic [MODE_W-1:0] in_mode;
  logic [POS_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_val;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     len_x;
  logic              accept;
  logic              out_free;
  logic              cmp_match;
  logic              cmp_emit;
  logic              cmp_retire;
  logic              issue;
  logic [POS_W-1:0]  cmp_pos;

  logic              out_load;
  logic [STAT_W-1:0] out_status;
  logic              out_found;
  logic [POS_W-1:0]  out_pos;
  logic              out_last;
  logic [STAT_W-1:0] m_status;
  logic              m_found;
  logic [POS_W-1:0]  m_pos;
  logic [POS_W-1:0]  m_count;

  assign in_mode  = s_tuser;
  assign in_pos   = s_tdata[POS_W-1:0];
  assign in_val   = s_tdata[POS_W+VAL_W-1:POS_W];
  assign pos_x    = XW'(in_pos);
  assign len_x    = XW'(length);
  assign s_tready = (state == S_IDLE) && !in_srch_end;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign cmp_match  = (rdata == val_reg);
  assign cmp_emit   = cmp_v && cmp_match && held_v;
  assign cmp_retire = cmp_v && (!cmp_emit || out_free);
  assign issue      = (state == S_SRCH) && issuing && (!cmp_v || cmp_retire);
  assign cmp_pos    = POS_W'(XW'(cmp_idx) + XW'(1));

  // Shift schedule keeps the read two entries away from the pending write.
  always_comb begin
    re    = 1'b0;
    we    = pend;
    waddr = pend_wa;
    wdata = rdata;
    unique case (state)
      S_INS, S_DEL: re = !in_srch_end;
      S_INS_PUT: begin
        we    = 1'b1;
        waddr = AW'(pos_reg - POS_W'(1));
        wdata = val_reg;
      end
      S_SRCH: re = issue;
      default: ;
    endcase
  end

  always_comb begin
    out_load   = 1'b0;
    out_status = st_reg;
    out_found  = 1'b0;
    out_pos    = '0;
    out_last   = 1'b1;
    if (in_srch_end) begin
      out_load   = out_free;
      out_status = ST_OK;
      out_found  = held_v;
      out_pos    = held_v ? held_pos : '0;
    end else if (state == S_RESP) begin
      out_load = out_free;
    end else if (state == S_SRCH) begin
      out_load   = cmp_emit && out_free;
      out_status = ST_OK;
      out_found  = 1'b1;
      out_pos    = held_pos;
      out_last   = 1'b0;
    end
  end

  ple_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(cur),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      in_srch_end <= 1'b0;
      length      <= '0;
      issuing     <= 1'b0;
      pend        <= 1'b0;
      cmp_v       <= 1'b0;
      held_v      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_status <= out_status;
        m_found  <= out_found;
        m_pos    <= out_pos;
        m_count  <= POS_W'(length);
        m_tlast  <= out_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (in_srch_end) begin
        if (out_free) begin
          in_srch_end <= 1'b0;
          held_v      <= 1'b0;
        end
      end else begin
        unique case (state)
          S_IDLE: begin
            if (accept) begin
              pos_reg <= in_pos;
              val_reg <= in_val;
              pend    <= 1'b0;
              unique case (in_mode)
                MODE_INSERT: begin
                  if (len_x >= XW'(CAPACITY)) begin
                    st_reg <= ST_FULL;
                    state  <= S_RESP;
                  end else if (in_pos == '0 || pos_x > len_x + XW'(1)) begin
                    st_reg <= ST_BAD_POS;
                    state  <= S_RESP;
                  end else if (pos_x == len_x + XW'(1)) begin
                    state <= S_INS_DRAIN;
                  end else begin
                    cur   <= AW'(length - CNT_W'(1));
                    state <= S_INS;
                  end
                end
                MODE_DELETE: begin
                  if (length == '0) begin
                    st_reg <= ST_EMPTY;
                    state  <= S_RESP;
                  end else if (in_pos == '0 || pos_x > len_x) begin
                    st_reg <= ST_BAD_POS;
                    state  <= S_RESP;
                  end else if (pos_x == len_x) begin
                    state <= S_DEL_DRAIN;
                  end else begin
                    cur   <= AW'(in_pos);
                    state <= S_DEL;
                  end
                end
                MODE_SEARCH: begin
                  held_v <= 1'b0;
                  cmp_v  <= 1'b0;
                  if (length == '0) begin
                    in_srch_end <= 1'b1;
                  end else begin
                    cur     <= '0;
                    issuing <= 1'b1;
                    state   <= S_SRCH;
                  end
                end
                default: ;
              endcase
            end
          end
          S_INS: begin
            pend    <= 1'b1;
            pend_wa <= AW'(cur + AW'(1));
            if (cur == AW'(pos_reg - POS_W'(1))) begin
              state <= S_INS_DRAIN;
            end else begin
              cur <= AW'(cur - AW'(1));
            end
          end
          S_INS_DRAIN: begin
            pend  <= 1'b0;
            state <= S_INS_PUT;
          end
          S_INS_PUT: begin
            length <= CNT_W'(length + CNT_W'(1));
            st_reg <= ST_OK;
            state  <= S_RESP;
          end
          S_DEL: begin
            pend    <= 1'b1;
            pend_wa <= AW'(cur - AW'(1));
            if (XW'(cur) == len_x - XW'(1)) begin
              state <= S_DEL_DRAIN;
            end else begin
              cur <= AW'(cur + AW'(1));
            end
          end
          S_DEL_DRAIN: begin
            pend   <= 1'b0;
            length <= CNT_W'(length - CNT_W'(1));
            st_reg <= ST_OK;
            state  <= S_RESP;
          end
          S_RESP: begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end
          S_SRCH: begin
            if (issue) begin
              cmp_v   <= 1'b1;
              cmp_idx <= cur;
              if (XW'(cur) == len_x - XW'(1)) begin
                issuing <= 1'b0;
              end else begin
                cur <= AW'(cur + AW'(1));
              end
            end else if (cmp_retire) begin
              cmp_v <= 1'b0;
            end
            if (cmp_retire && cmp_match) begin
              held_v   <= 1'b1;
              held_pos <= cmp_pos;
            end
            if (!issuing && !cmp_v) begin
              in_srch_end <= 1'b1;
              state       <= S_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign m_tdata = {4'b0, m_count, m_pos};
  assign m_tuser = {m_found, m_status};

  `PLE_ASSERT_NOW(a_len_bound, 1'b1, len_x <= XW'(CAPACITY), "entry count above capacity")
  `PLE_ASSERT_NOW(a_no_rw_clash, re && we, cur != waddr, "RAM read and write hit one entry")
  `PLE_ASSERT_NOW(a_srch_no_write, state == S_SRCH, !we, "RAM written during a search")
  `PLE_ASSERT_NEXT(a_len_step, 1'b1,
    length == $past(length) || length == CNT_W'($past(length) + CNT_W'(1)) ||
    length == CNT_W'($past(length) - CNT_W'(1)), "entry count jumped by more than one")

endmodule
